// File: rtl/core/substring_match_all_occurrences_defines.svh
// Assertion helpers for the substring matcher
`ifndef SUBSTRING_MATCH_ALL_OCCURRENCES_DEFINES_SVH
`define SUBSTRING_MATCH_ALL_OCCURRENCES_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SMAO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SMAO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/smao_pkg.sv
package smao_pkg;

  // Default sizes
  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam int unsigned TEXT_MAX_DEF    = 256;

  // Result queue depth (power of two, at least two)
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_e;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One result transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] match_start;
    logic       any_found;
    logic       truncated;
    logic       last_of_run;
  } res_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic pat_shift;
    logic txt_shift;
    logic txt_clear;
  } cell_ctrl_t;

endpackage

// File: rtl/core/smao_in_if.sv
interface smao_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;
  logic       is_last;

  modport source (output valid, output operation, output byte_value, output is_last,
                  input ready);
  modport sink (input valid, input operation, input byte_value, input is_last,
                output ready);
endinterface

// File: rtl/core/smao_out_if.sv
interface smao_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] match_start;
  logic       any_found;
  logic       truncated;
  logic       last_of_run;

  modport source (output valid, output kind, output match_start, output any_found,
                  output truncated, output last_of_run, input ready);
  modport sink (input valid, input kind, input match_start, input any_found,
                input truncated, input last_of_run, output ready);
endinterface

// File: rtl/core/smao_cell.sv
module smao_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smao_pkg::cell_ctrl_t   ctrl_i,
  input  logic [7:0]             pat_i,
  input  logic                   pv_i,
  input  logic [7:0]             txt_i,
  input  logic                   tv_i,
  output logic [7:0]             pat_o,
  output logic                   pv_o,
  output logic [7:0]             txt_o,
  output logic                   tv_o,
  output logic                   ok_o
);

  logic [7:0] pat_q;
  logic [7:0] txt_q;
  logic       pv_q;
  logic       tv_q;

  // Pattern byte and text byte payload, shifted from the neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.txt_shift) begin
      txt_q <= txt_i;
    end
  end

  // Occupancy bits for pattern and text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      tv_q <= 1'b0;
    end else begin
      if (ctrl_i.pat_shift) begin
        pv_q <= pv_i;
      end
      if (ctrl_i.txt_clear) begin
        tv_q <= 1'b0;
      end else if (ctrl_i.txt_shift) begin
        tv_q <= tv_i;
      end
    end
  end

  // Compare the text byte entering this cell against the held pattern byte
  assign ok_o  = !pv_q || (tv_i && (txt_i == pat_q));
  assign pat_o = pat_q;
  assign pv_o  = pv_q;
  assign txt_o = txt_q;
  assign tv_o  = tv_q;

endmodule

// File: rtl/core/smao_res_fifo.sv
module smao_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  smao_pkg::res_t   push_a_i,
  input  smao_pkg::res_t   push_b_i,
  output logic             space_o,
  smao_out_if.source       out_o
);
  import smao_pkg::*;

  localparam int unsigned PW = $clog2(RES_DEPTH);
  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  res_t          mem_q [RES_DEPTH];
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;
  logic [PW-1:0] wp_next;

  assign pop     = out_o.valid && out_o.ready;
  assign wp_next = wp_q + PW'(1);

  // Write up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp_next] <= push_b_i;
    end
  end

  // Advance pointers and fill level
  always_comb begin
    wp_d  = wp_q + PW'(push_cnt_i);
    rp_d  = pop ? rp_q + PW'(1) : rp_q;
    cnt_d = cnt_q + CW'(push_cnt_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Room for the worst case of two results from the next transaction
  assign space_o = (cnt_q <= CW'(RES_DEPTH - 2));

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.kind        = mem_q[rp_q].kind;
  assign out_o.match_start = mem_q[rp_q].match_start;
  assign out_o.any_found   = mem_q[rp_q].any_found;
  assign out_o.truncated   = mem_q[rp_q].truncated;
  assign out_o.last_of_run = mem_q[rp_q].last_of_run;

endmodule

// File: rtl/core/substring_match_all_occurrences.sv
// Substring matcher reporting every occurrence, overlapping ones included.
// Input channel in_i carries operation, byte_value and is_last. With
// operation 0 a pattern byte is loaded (is_last closes the pattern); with
// operation 1 a text byte is streamed. Output channel out_o returns match
// reports (start index of each occurrence) and, on the last text byte, a
// summary with any_found and truncated; last_of_run marks the final result
// of each input transaction.
// A row of PATTERN_MAX cells holds the pattern and a sliding text window;
// every cell compares its byte in the same cycle, so one transaction is
// taken per clock while in_i is ready. Results are registered into a
// four-entry result queue that drives out_o. The input is ready while
// the queue has room for two results, so a stalled receiver backs up into
// in_i once more than two results are pending.
// Reset clears the pattern length, the text run and the result queue; the
// pattern bytes themselves are not cleared. Text bytes past TEXT_MAX are
// dropped and reported as truncated in the summary.
module substring_match_all_occurrences #(
  parameter int unsigned PATTERN_MAX = smao_pkg::PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = smao_pkg::TEXT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smao_in_if.sink     in_i,
  smao_out_if.source  out_o
);
  import smao_pkg::*;

  localparam int unsigned PosW = $clog2(TEXT_MAX + 1);
  localparam int unsigned CntW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned SW   = (PosW > CntW) ? PosW : CntW;
  localparam int unsigned StW  = (SW > 8) ? SW : 8;

  // Cell chain wiring
  logic [7:0]             pat_in  [PATTERN_MAX];
  logic [7:0]             pat_out [PATTERN_MAX];
  logic [7:0]             txt_in  [PATTERN_MAX];
  logic [7:0]             txt_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pv_in, pv_out, tv_in, tv_out, ok;

  cell_ctrl_t    ctrl;
  logic          acc, is_pat, is_txt, room, full, restart, match;
  logic          complete_q, complete_d;
  logic          found_q, found_d;
  logic          dropped_q, dropped_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [StW-1:0]  start;
  logic [1:0]      push_cnt;
  logic            space;
  res_t            mres, sres, push_a;

  assign acc     = in_i.valid && in_i.ready;
  assign is_pat  = acc && (in_i.operation == OP_PATTERN);
  assign is_txt  = acc && (in_i.operation == OP_TEXT);
  assign room    = (pos_q < PosW'(TEXT_MAX));
  assign full    = pv_out[PATTERN_MAX-1];
  assign restart = complete_q;

  // Shift controls for the row
  always_comb begin
    ctrl.pat_shift = is_pat && (restart || !full);
    ctrl.txt_shift = is_txt && room;
    ctrl.txt_clear = is_pat || (is_txt && in_i.is_last);
  end

  // Build the row of cells; cell 0 takes the newest byte
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign pat_in[k] = in_i.byte_value;
      assign pv_in[k]  = 1'b1;
      assign txt_in[k] = in_i.byte_value;
      assign tv_in[k]  = 1'b1;
    end else begin : g_body
      assign pat_in[k] = pat_out[k-1];
      assign pv_in[k]  = pv_out[k-1] && !restart;
      assign txt_in[k] = txt_out[k-1];
      assign tv_in[k]  = tv_out[k-1];
    end

    smao_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pat_i  (pat_in[k]),
      .pv_i   (pv_in[k]),
      .txt_i  (txt_in[k]),
      .tv_i   (tv_in[k]),
      .pat_o  (pat_out[k]),
      .pv_o   (pv_out[k]),
      .txt_o  (txt_out[k]),
      .tv_o   (tv_out[k]),
      .ok_o   (ok[k])
    );
  end

  // Occurrence ends at the incoming text byte
  assign match = ctrl.txt_shift && complete_q && pv_out[0] && (&ok);
  assign start = StW'(pos_q) + StW'(1) - StW'(cnt_q);

  // Pattern length, text position and run flags
  always_comb begin
    complete_d = complete_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    found_d    = found_q;
    dropped_d  = dropped_q;
    if (is_pat) begin
      complete_d = in_i.is_last;
      if (restart) begin
        cnt_d = CntW'(1);
      end else if (!full) begin
        cnt_d = cnt_q + CntW'(1);
      end
      pos_d     = '0;
      found_d   = 1'b0;
      dropped_d = 1'b0;
    end else if (is_txt) begin
      if (in_i.is_last) begin
        pos_d     = '0;
        found_d   = 1'b0;
        dropped_d = 1'b0;
      end else begin
        if (room) begin
          pos_d = pos_q + PosW'(1);
        end
        found_d   = found_q || match;
        dropped_d = dropped_q || !room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      complete_q <= 1'b0;
      cnt_q      <= '0;
      pos_q      <= '0;
      found_q    <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      complete_q <= complete_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      found_q    <= found_d;
      dropped_q  <= dropped_d;
    end
  end

  // Form the match report and the summary
  always_comb begin
    mres.kind        = KIND_MATCH;
    mres.match_start = start[7:0];
    mres.any_found   = 1'b0;
    mres.truncated   = 1'b0;
    mres.last_of_run = !in_i.is_last;

    sres.kind        = KIND_SUMMARY;
    sres.match_start = 8'd0;
    sres.any_found   = found_q || match;
    sres.truncated   = dropped_q || !room;
    sres.last_of_run = 1'b1;

    push_a   = match ? mres : sres;
    push_cnt = 2'(match) + 2'(is_txt && in_i.is_last);
  end

  smao_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_a_i   (push_a),
    .push_b_i   (sres),
    .space_o    (space),
    .out_o      (out_o)
  );

  assign in_i.ready = space;

endmodule

// File: rtl/core/smao_checker.sv
`include "substring_match_all_occurrences_defines.svh"

module smao_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] out_match_start_i,
  input logic       out_any_found_i,
  input logic       out_truncated_i,
  input logic       out_last_of_run_i
);
  import smao_pkg::*;

  // A summary always closes the results of its transaction
  `SMAO_ASSERT_NOW(a_summary_last, out_valid_i && (out_kind_i == KIND_SUMMARY), out_last_of_run_i, "summary without last_of_run")

  // Match reports carry no summary flags
  `SMAO_ASSERT_NOW(a_match_clean, out_valid_i && (out_kind_i == KIND_MATCH), !out_any_found_i && !out_truncated_i, "match report with summary flags set")

  // A match that is not last is followed at once by its summary
  `SMAO_ASSERT_NEXT(a_summary_follows, out_valid_i && out_ready_i && (out_kind_i == KIND_MATCH) && !out_last_of_run_i, out_valid_i && (out_kind_i == KIND_SUMMARY), "summary does not follow a non-final match")

  // No result appears without an accepted input
  `SMAO_ASSERT_NOW(a_no_spurious, $rose(out_valid_i), $past(in_valid_i && in_ready_i), "result without an accepted input")

  // Stalled result holds
  `SMAO_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_match_start_i) && $stable(out_kind_i), "stalled result changed")

endmodule

bind substring_match_all_occurrences smao_checker u_smao_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_match_start_i (out_o.match_start),
  .out_any_found_i   (out_o.any_found),
  .out_truncated_i   (out_o.truncated),
  .out_last_of_run_i (out_o.last_of_run)
);

// File: tb/sv/tb_substring_match_all_occurrences.sv
`timescale 1ns / 100ps

module tb_substring_match_all_occurrences;
  import smao_pkg::*;

  localparam int unsigned PMAX      = PATTERN_MAX_DEF;
  localparam int unsigned TMAX      = TEXT_MAX_DEF;
  localparam int unsigned RAND_GOAL = 170;
  localparam int unsigned CYC_LIMIT = 400000;
  localparam int unsigned TAIL_CYC  = 12;

  logic clk_i;
  logic rst_ni;

  smao_in_if  in_bus ();
  smao_out_if out_bus ();

  substring_match_all_occurrences u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Shadow state of the matcher
  logic [7:0]  pat_mem [PMAX];
  int unsigned pat_len;
  bit          pat_done;
  logic [7:0]  txt_win [PMAX];
  int unsigned txt_pos;
  bit          seen_hit;
  bit          txt_cut;

  // Expected result transactions, oldest first
  res_t results_due[$];

  int unsigned err_count;
  int unsigned sent_count;
  int unsigned cyc_count;

  // Sender pacing
  int unsigned burst_left;
  int unsigned gap_max;

  // Stimulus helpers: small alphabet and the current pattern for planting
  logic [7:0]  alph [4];
  int unsigned alph_n;
  logic [7:0]  cur_pat [40];
  int unsigned cur_len;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial cyc_count = 0;
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Abandon the text run in progress
  function automatic void clear_run();
    for (int k = 0; k < PMAX; k++) txt_win[k] = 8'h00;
    txt_pos  = 0;
    seen_hit = 1'b0;
    txt_cut  = 1'b0;
  endfunction

  // Advance the shadow state by one accepted transaction and queue its results
  function automatic void predict_matches(input op_e op, input logic [7:0] value,
                                          input logic last);
    res_t        r;
    bit          hit;
    int unsigned start;
    hit   = 1'b0;
    start = 0;
    if (op == OP_PATTERN) begin
      if (pat_done) begin
        pat_len  = 0;
        pat_done = 1'b0;
      end
      if (pat_len < PMAX) begin
        pat_mem[pat_len] = value;
        pat_len++;
      end
      if (last) pat_done = 1'b1;
      clear_run();
      return;
    end
    if (txt_pos < TMAX) begin
      for (int k = PMAX - 1; k > 0; k--) txt_win[k] = txt_win[k-1];
      txt_win[0] = value;
      txt_pos++;
      if (pat_done && pat_len > 0 && txt_pos >= pat_len) begin
        hit = 1'b1;
        for (int k = 0; k < pat_len; k++)
          if (txt_win[k] != pat_mem[pat_len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        start    = txt_pos - pat_len;
        seen_hit = 1'b1;
      end
    end else begin
      txt_cut = 1'b1;
    end
    if (hit) begin
      r.kind        = KIND_MATCH;
      r.match_start = start[7:0];
      r.any_found   = 1'b0;
      r.truncated   = 1'b0;
      r.last_of_run = !last;
      results_due.push_back(r);
    end
    if (last) begin
      r.kind        = KIND_SUMMARY;
      r.match_start = 8'h00;
      r.any_found   = seen_hit;
      r.truncated   = txt_cut;
      r.last_of_run = 1'b1;
      results_due.push_back(r);
      clear_run();
    end
  endfunction

  // Send one input transaction, with bursts and random gaps in between
  task automatic send_item(input op_e op, input logic [7:0] value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.byte_value <= value;
    in_bus.is_last    <= last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_matches(op, value, last);
    sent_count++;
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void new_alphabet(input int unsigned n);
    alph_n = n;
    for (int i = 0; i < n; i++) alph[i] = 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_char();
    return alph[$urandom_range(0, alph_n - 1)];
  endfunction

  task automatic send_pattern(input int unsigned len, input bit close);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = pick_char();
      if (i < 40) cur_pat[i] = c;
      send_item(OP_PATTERN, c, close && (i == len - 1));
    end
    cur_len = (len > PMAX) ? PMAX : len;
  endtask

  // Random text from the alphabet with copies of the pattern planted in it
  task automatic send_text(input int unsigned len, input int unsigned plant_pct);
    logic [7:0]  vals[];
    int unsigned i;
    vals = new[len];
    i = 0;
    while (i < len) begin
      if (cur_len > 0 && i + cur_len <= len && $urandom_range(0, 99) < plant_pct) begin
        for (int k = 0; k < cur_len; k++) vals[i+k] = cur_pat[k];
        i += cur_len;
      end else begin
        vals[i] = pick_char();
        i++;
      end
    end
    for (int k = 0; k < len; k++) send_item(OP_TEXT, vals[k], k == len - 1);
  endtask

  // Compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind=%0d match_start=%0d any_found=%0d truncated=%0d",
               out_bus.kind, out_bus.match_start, out_bus.any_found, out_bus.truncated);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (out_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
          err_count++;
        end
        if (out_bus.match_start !== want.match_start) begin
          $error("match_start: expected %0d, got %0d", want.match_start, out_bus.match_start);
          err_count++;
        end
        if (out_bus.any_found !== want.any_found) begin
          $error("any_found: expected %0d, got %0d", want.any_found, out_bus.any_found);
          err_count++;
        end
        if (out_bus.truncated !== want.truncated) begin
          $error("truncated: expected %0d, got %0d", want.truncated, out_bus.truncated);
          err_count++;
        end
        if (out_bus.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_bus.last_of_run);
          err_count++;
        end
      end
    end
  end

  // Receiver stalls: always ready, random, short periodic and long periodic
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned ph;
    out_bus.ready = 1'b0;
    mode = 0;
    left = 0;
    ph   = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      ph++;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 1) == 1);
        2: out_bus.ready <= ((ph % 3) != 0);
        default: out_bus.ready <= ((ph % 12) < 4);
      endcase
    end
  end

  // Extremes of the byte field, overlaps, zero byte, text without pattern,
  // unclosed pattern, and a new pattern replacing the old one
  task automatic test_directed();
    gap_max = 3;
    send_item(OP_TEXT, 8'h41, 1'b1);
    send_item(OP_PATTERN, 8'h01, 1'b0);
    send_item(OP_PATTERN, 8'hFF, 1'b1);
    send_item(OP_TEXT, 8'h01, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b0);
    send_item(OP_TEXT, 8'h01, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b1);
    send_item(OP_PATTERN, 8'h80, 1'b0);
    send_item(OP_PATTERN, 8'h80, 1'b1);
    send_item(OP_TEXT, 8'h80, 1'b0);
    send_item(OP_TEXT, 8'h80, 1'b0);
    send_item(OP_TEXT, 8'h80, 1'b0);
    send_item(OP_TEXT, 8'h80, 1'b1);
    send_item(OP_PATTERN, 8'h00, 1'b1);
    send_item(OP_TEXT, 8'h7F, 1'b0);
    send_item(OP_TEXT, 8'h00, 1'b1);
    send_item(OP_PATTERN, 8'h33, 1'b0);
    send_item(OP_TEXT, 8'h33, 1'b1);
    send_item(OP_PATTERN, 8'h44, 1'b1);
    send_item(OP_TEXT, 8'h33, 1'b0);
    send_item(OP_TEXT, 8'h44, 1'b1);
    send_item(OP_PATTERN, 8'h33, 1'b0);
    send_item(OP_TEXT, 8'h33, 1'b0);
    send_item(OP_TEXT, 8'h33, 1'b1);
    drain_results();
  endtask

  // Patterns at and past the maximum length
  task automatic test_long_pattern();
    gap_max = 0;
    new_alphabet(4);
    send_pattern(34, 1'b1);
    send_text(40, 50);
    new_alphabet(2);
    send_pattern(PMAX, 1'b1);
    send_text(48, 40);
    drain_results();
  endtask

  // Text one byte past the maximum length
  task automatic test_long_text();
    gap_max = 2;
    new_alphabet(2);
    send_pattern(1, 1'b1);
    send_text(TMAX + 1, 0);
    drain_results();
  endtask

  // Mostly well-formed pattern/text sequences, some noise and broken ones
  task automatic test_random();
    int unsigned first;
    int unsigned ntext;
    first = sent_count;
    while (sent_count - first < RAND_GOAL) begin
      if ($urandom_range(0, 7) == 0) gap_max = ($urandom_range(0, 1) == 1) ? 0 : 6;
      if ($urandom_range(0, 2) == 0) new_alphabet($urandom_range(1, 4));
      case ($urandom_range(0, 9))
        0: send_text($urandom_range(1, 12), 20);
        1: begin
          send_pattern($urandom_range(1, 4), 1'b0);
          send_text($urandom_range(1, 10), 30);
        end
        2: send_pattern($urandom_range(1, 3), 1'($urandom_range(0, 1)));
        default: begin
          if ($urandom_range(0, 9) == 0) send_pattern($urandom_range(1, 36), 1'b1);
          else send_pattern($urandom_range(1, 5), 1'b1);
          ntext = $urandom_range(1, 3);
          for (int t = 0; t < ntext; t++) begin
            send_text($urandom_range(1, 40), 30);
          end
        end
      endcase
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_PATTERN;
    in_bus.byte_value = 8'h00;
    in_bus.is_last    = 1'b0;
    err_count  = 0;
    sent_count = 0;
    burst_left = 0;
    gap_max    = 0;
    cur_len    = 0;
    alph_n     = 1;
    alph[0]    = 8'h01;
    pat_len    = 0;
    pat_done   = 1'b0;
    for (int k = 0; k < PMAX; k++) pat_mem[k] = 8'h00;
    clear_run();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_pattern();
    test_long_text();
    test_random();

    // Let any stray result show up before the verdict
    repeat (TAIL_CYC) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/smao_pkg.sv
rtl/core/smao_in_if.sv
rtl/core/smao_out_if.sv
rtl/core/smao_cell.sv
rtl/core/smao_res_fifo.sv
rtl/core/substring_match_all_occurrences.sv
rtl/core/smao_checker.sv
tb/sv/tb_substring_match_all_occurrences.sv
